// ----- rtl/fir_pkg.sv -----
// Shared constants, types and control structs of the FIR filter.
`timescale 1ns / 1ps

package fir_pkg;

    localparam int MAX_TAPS   = 63;
    localparam int ADDR_W     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W      = $clog2(MAX_TAPS + 1);

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int IDX_W      = 6;
    localparam int NTAPS_W    = 6;
    localparam int MULT_W     = 16;
    localparam int SHIFT_W    = 6;
    localparam int CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + CNT_W;
    localparam int SCALE_W    = ACC_W + MULT_W + 1;

    localparam int S_FIELDS_W = SAMPLE_W + IDX_W + COEF_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = SAMPLE_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_COEF = 1'b1;

    localparam logic signed [SCALE_W-1:0] SAT_HI = SCALE_W'(32767);
    localparam logic signed [SCALE_W-1:0] SAT_LO = SCALE_W'(-32768);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_TAPS   = 2'd0,
        CFG_NORM_MULT  = 2'd1,
        CFG_NORM_SHIFT = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_MUL,
        ST_SHIFT,
        ST_EMIT
    } fsm_state_t;

    typedef struct packed {
        logic              hist_we;
        logic              tap_we;
        logic              acc_clr;
        logic              pos_load;
        logic              issue;
        logic              mul_en;
        logic              shift_en;
        logic              out_load;
        logic [ADDR_W-1:0] tap_addr;
    } dp_cmd_t;

    typedef struct packed {
        logic mac_busy;
    } dp_sts_t;

endpackage

// ----- rtl/fir_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/fir_ctrl.sv -----
// Sequencer for the FIR filter: transaction handshakes and tap loop control.
`timescale 1ns / 1ps

module fir_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic                     func,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [fir_pkg::NTAPS_W-1:0] tap_count,
    output fir_pkg::dp_cmd_t         cmd,
    input  fir_pkg::dp_sts_t         sts
);
    import fir_pkg::*;

    fsm_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0]  taps_reg, taps_next;
    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  taps_cfg;
    logic              accept_push;
    logic              last_tap;

    assign taps_cfg = (CMP_W'(tap_count) > CMP_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS)
                                                              : CNT_W'(tap_count);
    assign accept_push = (state_reg == ST_IDLE) && s_tvalid && (func == FUNC_PUSH);
    assign last_tap    = (CNT_W'(j_reg) == taps_reg - CNT_W'(1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept_push) begin
                    state_next = (taps_cfg == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!sts.mac_busy) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_SHIFT;
            ST_SHIFT: state_next = ST_EMIT;
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (func == FUNC_COEF) begin
                        cmd.tap_we = 1'b1;
                    end else begin
                        cmd.hist_we  = 1'b1;
                        cmd.pos_load = 1'b1;
                        cmd.acc_clr  = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                cmd.issue    = 1'b1;
                cmd.tap_addr = j_reg;
            end
            ST_DRAIN: ;
            ST_MUL:   cmd.mul_en   = 1'b1;
            ST_SHIFT: cmd.shift_en = 1'b1;
            ST_EMIT:  cmd.out_load = !out_valid_reg || m_tready;
            default: ;
        endcase
    end

    always_comb begin
        j_next         = j_reg;
        taps_next      = taps_reg;
        out_valid_next = out_valid_reg;
        if (accept_push) begin
            j_next    = '0;
            taps_next = taps_cfg;
        end else if (cmd.issue) begin
            j_next = j_reg + ADDR_W'(1);
        end
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            j_reg         <= '0;
            taps_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            taps_reg      <= taps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ----- rtl/fir_dp.sv -----
// FIR datapath: delay line, tap table, shared MAC, scaling and saturation.
`timescale 1ns / 1ps

module fir_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  fir_pkg::dp_cmd_t                   cmd,
    output fir_pkg::dp_sts_t                   sts,
    input  logic signed [fir_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [fir_pkg::IDX_W-1:0]          tap_index,
    input  logic signed [fir_pkg::COEF_W-1:0]  tap_value,
    input  logic [fir_pkg::MULT_W-1:0]         norm_mult,
    input  logic [fir_pkg::SHIFT_W-1:0]        norm_shift,
    output logic signed [fir_pkg::SAMPLE_W-1:0] filtered_sample
);
    import fir_pkg::*;

    logic [ADDR_W-1:0]          head_reg;
    logic [ADDR_W-1:0]          pos_reg;
    logic [MAX_TAPS-1:0]        hist_vld_reg;
    logic                       hv_reg;
    logic                       rd_vld_reg;
    logic                       prod_vld_reg;
    logic [SAMPLE_W-1:0]        hist_rdata;
    logic [COEF_W-1:0]          tap_rdata;
    logic signed [SAMPLE_W-1:0] sample_v;
    logic signed [COEF_W-1:0]   coef_v;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SCALE_W-1:0]  scale_reg;
    logic signed [SCALE_W-1:0]  shift_reg;
    logic signed [SAMPLE_W-1:0] sat_v;
    logic signed [SAMPLE_W-1:0] out_reg;
    logic                       tap_wr;

    assign tap_wr = cmd.tap_we && (CMP_W'(tap_index) < CMP_W'(MAX_TAPS));

    fir_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_hist_ram (
        .aclk  (aclk),
        .we    (cmd.hist_we),
        .waddr (head_reg),
        .wdata (sample_in),
        .raddr (pos_reg),
        .rdata (hist_rdata)
    );

    fir_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_tap_ram (
        .aclk  (aclk),
        .we    (tap_wr),
        .waddr (ADDR_W'(tap_index)),
        .wdata (tap_value),
        .raddr (cmd.tap_addr),
        .rdata (tap_rdata)
    );

    // slots never written read as zero history
    assign sample_v = hv_reg ? $signed(hist_rdata) : '0;
    assign coef_v   = $signed(tap_rdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            pos_reg      <= '0;
            hist_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= cmd.issue;
            prod_vld_reg <= rd_vld_reg;
            if (cmd.hist_we) begin
                hist_vld_reg[head_reg] <= 1'b1;
                head_reg <= (head_reg == ADDR_W'(MAX_TAPS - 1)) ? '0
                                                                : head_reg + ADDR_W'(1);
            end
            if (cmd.pos_load) begin
                pos_reg <= head_reg;
            end else if (cmd.issue) begin
                pos_reg <= (pos_reg == '0) ? ADDR_W'(MAX_TAPS - 1) : pos_reg - ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        hv_reg   <= hist_vld_reg[pos_reg];
        prod_reg <= coef_v * sample_v;
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.mul_en) begin
            scale_reg <= acc_reg * $signed({1'b0, norm_mult});
        end
        if (cmd.shift_en) begin
            shift_reg <= scale_reg >>> norm_shift;
        end
        if (cmd.out_load) begin
            out_reg <= sat_v;
        end
    end

    always_comb begin
        if (shift_reg > SAT_HI) begin
            sat_v = SAMPLE_W'(SAT_HI);
        end else if (shift_reg < SAT_LO) begin
            sat_v = SAMPLE_W'(SAT_LO);
        end else begin
            sat_v = SAMPLE_W'(shift_reg);
        end
    end

    assign sts.mac_busy    = rd_vld_reg | prod_vld_reg;
    assign filtered_sample = out_reg;

endmodule

// ----- rtl/fir_filter_int16_saturating_top.sv -----
// Top level of the saturating 16-bit direct-form FIR filter.
// Sample transaction: MAC over the n taps in use, then scale, shift, saturate and emit.
// Coefficient transaction: accepted while idle, no result.
// Samples do not overlap on the single shared MAC: a new one waits until the last is emitted.
// The output register lets a new transaction enter while a result waits.
// Reset (sync, active low): delay line reads zero, tap count 1, norm_mult 1, norm_shift 0.
`timescale 1ns / 1ps

module fir_filter_int16_saturating_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fir_pkg::S_TDATA_W-1:0]   s_tdata,  // sample_in, tap_index, tap_value
    input  logic                            s_tuser,  // func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fir_pkg::M_TDATA_W-1:0]   m_tdata,  // filtered_sample
    input  logic                            cfg_wr_en,
    input  logic [fir_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fir_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fir_pkg::*;

    localparam int TAP_IDX_LO = SAMPLE_W;
    localparam int TAP_VAL_LO = SAMPLE_W + IDX_W;

    logic [NTAPS_W-1:0]         tap_count_reg;
    logic [MULT_W-1:0]          norm_mult_reg;
    logic [SHIFT_W-1:0]         norm_shift_reg;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [IDX_W-1:0]           tap_index;
    logic signed [COEF_W-1:0]   tap_value;
    logic signed [SAMPLE_W-1:0] filtered_sample;
    dp_cmd_t                    cmd;
    dp_sts_t                    sts;

    assign sample_in = $signed(s_tdata[SAMPLE_W-1:0]);
    assign tap_index = s_tdata[TAP_IDX_LO +: IDX_W];
    assign tap_value = $signed(s_tdata[TAP_VAL_LO +: COEF_W]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg  <= NTAPS_W'(1);
            norm_mult_reg  <= MULT_W'(1);
            norm_shift_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_NUM_TAPS:   tap_count_reg  <= cfg_data[NTAPS_W-1:0];
                CFG_NORM_MULT:  norm_mult_reg  <= cfg_data[MULT_W-1:0];
                CFG_NORM_SHIFT: norm_shift_reg <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    fir_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .func      (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .tap_count (tap_count_reg),
        .cmd       (cmd),
        .sts       (sts)
    );

    fir_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .sample_in       (sample_in),
        .tap_index       (tap_index),
        .tap_value       (tap_value),
        .norm_mult       (norm_mult_reg),
        .norm_shift      (norm_shift_reg),
        .filtered_sample (filtered_sample)
    );

    assign m_tdata = filtered_sample;

endmodule

// ----- rtl/fir_chk.sv -----
// Port-level assertions for the FIR filter top level, with its bind.
`timescale 1ns / 1ps

module fir_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fir_pkg::M_TDATA_W-1:0] m_tdata
);
    import fir_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_coef_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == FUNC_COEF && !m_tvalid |=> !m_tvalid)
        else $error("coefficient transaction produced a result");

    a_push_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == FUNC_PUSH |=> !s_tready)
        else $error("sample transaction did not occupy the filter");

endmodule

bind fir_filter_int16_saturating_top fir_chk u_fir_chk (.*);
